// File: hdl/rma_pkg.sv
// Package for the resource map allocator.
// Holds table geometry, status and mode codes, the entry type and the
// sequencer state type. No dependencies.
package rma_pkg;

    localparam int MAP_ENTRIES = 64;
    localparam int ADDR_W      = 24;
    localparam int IDX_W       = $clog2(MAP_ENTRIES);

    // Largest number of extents the table may hold.
    localparam logic [IDX_W-1:0] MAX_USED = IDX_W'(MAP_ENTRIES - 1);
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}};

    // Request modes.
    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_FREE     = 2'd1;
    localparam logic [1:0] MODE_ALLOC_AT = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FIT     = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;

    // One free extent of the map.
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
    } entry_t;

    // Request operands seen by the compare unit.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W:0]   req_end;
    } req_t;

    // Flags and values that the compare unit derives from one entry.
    typedef struct packed {
        logic              len_ge_size;
        logic              len_sub_zero;
        logic [ADDR_W-1:0] len_sub;
        logic [ADDR_W-1:0] start_add;
        logic              start_le_addr;
        logic              addr_lt_start;
        logic              end_le_entry;
        logic              start_eq_addr;
        logic              end_eq_entry;
        logic [ADDR_W-1:0] addr_sub_start;
        logic [ADDR_W-1:0] entry_sub_end;
        logic              end_eq_start;
        logic              entry_end_eq_addr;
    } alu_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_FREE,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

endpackage

// File: hdl/rma_ram.sv
// Extent table storage: one write port and one registered read port.
// Depends on rma_pkg for the entry type and table depth.
module rma_ram
    import rma_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAP_ENTRIES];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/rma_alu.sv
// Shared compare and add unit applied to one table entry per step.
// Depends on rma_pkg for the entry, request and result types.
module rma_alu
    import rma_pkg::*;
(
    input  entry_t   entry,
    input  req_t     req,
    output alu_res_t res
);

    logic [ADDR_W:0] entry_end;

    always_comb
    begin
        // End of the extent, one bit wider than an address.
        entry_end             = {1'b0, entry.start} + {1'b0, entry.len};
        res.len_ge_size       = (entry.len >= req.size);
        res.len_sub           = entry.len - req.size;
        res.len_sub_zero      = (entry.len == req.size);
        res.start_add         = entry.start + req.size;
        res.start_le_addr     = (entry.start <= req.addr);
        res.addr_lt_start     = (req.addr < entry.start);
        res.end_le_entry      = (req.req_end <= entry_end);
        res.start_eq_addr     = (entry.start == req.addr);
        res.end_eq_entry      = (req.req_end == entry_end);
        res.addr_sub_start    = req.addr - entry.start;
        res.entry_sub_end     = ADDR_W'(entry_end - req.req_end);
        res.end_eq_start      = (req.req_end == {1'b0, entry.start});
        res.entry_end_eq_addr = (entry_end == {1'b0, req.addr});
    end

endmodule

// File: hdl/resource_map_allocator.sv
// Resource map allocator top level: request sequencer, extent table and
// compare unit. Depends on rma_pkg, rma_ram and rma_alu.
//
// Usage: a request beat (mode, start_addr, length) is taken on the input
// channel when in_valid is high and in_stall is low. Mode 0 allocates
// first fit, mode 1 frees an extent, mode 2 claims a given range. Each
// request gives exactly one result beat (base, status) on the output
// channel, taken when out_valid is high and out_stall is low.
// The block handles one request at a time: in_stall stays high from the
// accepted beat until its result beat has been taken.
// The table is scanned one entry at a time (read, then check), since the
// table RAM has one registered read port, and a join or insert that moves
// entries does a read and then a write for each moved entry. Scanned plus
// moved entries never exceed about 64, even with a full table of 63
// extents, and the next request is taken in the cycle after its result beat.
// While the receiver stalls, the result beat is held steady and no new
// request is taken. Reset empties the table at once through the entry
// count; no clearing pass is needed.
module resource_map_allocator
    import rma_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [ADDR_W-1:0] start_addr,
    input  logic [ADDR_W-1:0] length,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] base,
    output logic [1:0]        status
);

    state_t            state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] size_reg, size_next;
    logic [ADDR_W:0]   end_reg, end_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  used_reg, used_next;
    logic              have_prev_reg, have_prev_next;
    logic              pj_reg, pj_next;
    entry_t            prev_reg, prev_next;
    logic              next_valid_reg, next_valid_next;
    logic              nj_reg, nj_next;
    entry_t            nxt_reg, nxt_entry_next;
    logic [IDX_W-1:0]  sh_k_reg, sh_k_next;
    logic [IDX_W-1:0]  sh_tgt_reg, sh_tgt_next;
    logic              sh_ins_reg, sh_ins_next;
    entry_t            ins_reg, ins_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [1:0]        status_reg, status_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_wr_addr;
    entry_t            ram_wr_data;
    logic [IDX_W-1:0]  ram_rd_addr;
    entry_t            ram_rd_data;

    req_t              alu_req;
    alu_res_t          alu_res;

    logic [ADDR_W:0]   in_end;
    logic              prev_join;
    logic              next_join;

    rma_ram u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign alu_req.addr    = addr_reg;
    assign alu_req.size    = size_reg;
    assign alu_req.req_end = end_reg;

    rma_alu u_alu (
        .entry (ram_rd_data),
        .req   (alu_req),
        .res   (alu_res)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign base      = base_reg;
    assign status    = status_reg;

    assign in_end    = {1'b0, start_addr} + {1'b0, length};
    assign prev_join = have_prev_reg && pj_reg;
    assign next_join = next_valid_reg && nj_reg;

    // Registers: control state under reset, payload without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        size_reg       <= size_next;
        end_reg        <= end_next;
        idx_reg        <= idx_next;
        have_prev_reg  <= have_prev_next;
        pj_reg         <= pj_next;
        prev_reg       <= prev_next;
        next_valid_reg <= next_valid_next;
        nj_reg         <= nj_next;
        nxt_reg        <= nxt_entry_next;
        sh_k_reg       <= sh_k_next;
        sh_tgt_reg     <= sh_tgt_next;
        sh_ins_reg     <= sh_ins_next;
        ins_reg        <= ins_next;
        base_reg       <= base_next;
        status_reg     <= status_next;
    end

    // Sequencer: next state, table accesses and result.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        size_next       = size_reg;
        end_next        = end_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        have_prev_next  = have_prev_reg;
        pj_next         = pj_reg;
        prev_next       = prev_reg;
        next_valid_next = next_valid_reg;
        nj_next         = nj_reg;
        nxt_entry_next  = nxt_reg;
        sh_k_next       = sh_k_reg;
        sh_tgt_next     = sh_tgt_reg;
        sh_ins_next     = sh_ins_reg;
        ins_next        = ins_reg;
        base_next       = base_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = ram_rd_data;
        ram_rd_addr     = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode;
                    addr_next       = start_addr;
                    size_next       = length;
                    end_next        = in_end;
                    idx_next        = '0;
                    have_prev_next  = 1'b0;
                    next_valid_next = 1'b0;
                    base_next       = '0;
                    status_next     = ST_OK;
                    // A freed extent is clipped to the top of the address space.
                    if (mode == MODE_FREE && in_end > {1'b0, ADDR_MASK})
                    begin
                        size_next = ADDR_MASK - start_addr;
                        end_next  = {1'b0, ADDR_MASK};
                    end
                    if (mode == MODE_UNUSED || (mode == MODE_ALLOC_AT && length == '0))
                    begin
                        status_next = ST_NO_FIT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end

            S_RD:
            begin
                ram_rd_addr = idx_reg;
                if (idx_reg == used_reg)
                begin
                    // End of the used part of the table.
                    if (mode_reg == MODE_FREE)
                    begin
                        state_next = S_FREE;
                    end
                    else
                    begin
                        status_next = ST_NO_FIT;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (alu_res.len_ge_size)
                        begin
                            base_next = ram_rd_data.start;
                            if (alu_res.len_sub_zero)
                            begin
                                sh_k_next   = idx_reg;
                                sh_ins_next = 1'b0;
                                state_next  = S_SH_RD;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_wr_addr = idx_reg;
                                ram_wr_data = '{start: alu_res.start_add, len: alu_res.len_sub};
                                state_next  = S_DONE;
                            end
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end

                    MODE_FREE:
                    begin
                        if (alu_res.start_le_addr)
                        begin
                            prev_next      = ram_rd_data;
                            have_prev_next = 1'b1;
                            pj_next        = alu_res.entry_end_eq_addr;
                            idx_next       = idx_reg + 1'b1;
                            state_next     = S_RD;
                        end
                        else
                        begin
                            nxt_entry_next  = ram_rd_data;
                            next_valid_next = 1'b1;
                            nj_next         = alu_res.end_eq_start;
                            state_next      = S_FREE;
                        end
                    end

                    default:
                    begin
                        // Claim of a given range.
                        if (alu_res.addr_lt_start)
                        begin
                            status_next = ST_NO_FIT;
                            state_next  = S_DONE;
                        end
                        else if (alu_res.end_le_entry)
                        begin
                            if (alu_res.start_eq_addr)
                            begin
                                if (alu_res.len_sub_zero)
                                begin
                                    sh_k_next   = idx_reg;
                                    sh_ins_next = 1'b0;
                                    state_next  = S_SH_RD;
                                end
                                else
                                begin
                                    ram_we      = 1'b1;
                                    ram_wr_data = '{start: end_reg[ADDR_W-1:0],
                                                    len: alu_res.len_sub};
                                    state_next  = S_DONE;
                                end
                            end
                            else if (!alu_res.end_eq_entry)
                            begin
                                // Split: trim this extent, insert the tail after it.
                                if (used_reg == MAX_USED)
                                begin
                                    status_next = ST_TABLE_FULL;
                                    state_next  = S_DONE;
                                end
                                else
                                begin
                                    ram_we      = 1'b1;
                                    ram_wr_data = '{start: ram_rd_data.start,
                                                    len: alu_res.addr_sub_start};
                                    sh_k_next   = used_reg;
                                    sh_tgt_next = idx_reg + 1'b1;
                                    sh_ins_next = 1'b1;
                                    ins_next    = '{start: end_reg[ADDR_W-1:0],
                                                    len: alu_res.entry_sub_end};
                                    state_next  = S_SH_RD;
                                end
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_wr_data = '{start: ram_rd_data.start,
                                                len: alu_res.addr_sub_start};
                                state_next  = S_DONE;
                            end
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                endcase
            end

            S_FREE:
            begin
                // Join to the extent before, after, both, or insert a new one.
                if (prev_join)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = idx_reg - 1'b1;
                    if (next_join)
                    begin
                        ram_wr_data = '{start: prev_reg.start,
                                        len: prev_reg.len + size_reg + nxt_reg.len};
                        sh_k_next   = idx_reg;
                        sh_ins_next = 1'b0;
                        state_next  = S_SH_RD;
                    end
                    else
                    begin
                        ram_wr_data = '{start: prev_reg.start, len: prev_reg.len + size_reg};
                        state_next  = S_DONE;
                    end
                end
                else if (next_join)
                begin
                    ram_we      = 1'b1;
                    ram_wr_data = '{start: nxt_reg.start - size_reg,
                                    len: nxt_reg.len + size_reg};
                    state_next  = S_DONE;
                end
                else if (size_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (used_reg == MAX_USED)
                begin
                    status_next = ST_TABLE_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    sh_k_next   = used_reg;
                    sh_tgt_next = idx_reg;
                    sh_ins_next = 1'b1;
                    ins_next    = '{start: addr_reg, len: size_reg};
                    state_next  = S_SH_RD;
                end
            end

            S_SH_RD:
            begin
                if (sh_ins_reg)
                begin
                    // Move entries up from the end; then place the new entry.
                    ram_rd_addr = sh_k_reg - 1'b1;
                    if (sh_k_reg == sh_tgt_reg)
                    begin
                        ram_we      = 1'b1;
                        ram_wr_addr = sh_tgt_reg;
                        ram_wr_data = ins_reg;
                        used_next   = used_reg + 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SH_WR;
                    end
                end
                else
                begin
                    // Move entries down over the dropped one.
                    ram_rd_addr = sh_k_reg + 1'b1;
                    if ({1'b0, sh_k_reg} + 1'b1 >= {1'b0, used_reg})
                    begin
                        used_next  = used_reg - 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SH_WR;
                    end
                end
            end

            S_SH_WR:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = sh_k_reg;
                ram_wr_data = ram_rd_data;
                if (sh_ins_reg)
                begin
                    sh_k_next = sh_k_reg - 1'b1;
                end
                else
                begin
                    sh_k_next = sh_k_reg + 1'b1;
                end
                state_next = S_SH_RD;
            end

            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
